// ===== src/dque_pkg.sv =====
// Shared constants, codes and controller/datapath link types for the deque block.
package dque_pkg;

	localparam int unsigned OPCODE_W       = 3;
	localparam int unsigned VALUE_W        = 32;
	localparam int unsigned STATUS_W       = 2;
	localparam int unsigned OCC_W          = 5;
	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_INS_SECOND = 3'd2,
		OP_INS_NLAST  = 3'd3,
		OP_POP_FIRST  = 3'd4,
		OP_POP_SECOND = 3'd5,
		OP_POP_LAST   = 3'd6,
		OP_LIST       = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_ONE   = 2'd3
	} st_t;

	// Ring slot selectors, all relative to the current head, count or list index.
	typedef enum logic [2:0] {
		ADDR_HEAD,
		ADDR_HEAD_M1,
		ADDR_HEAD_P1,
		ADDR_LAST,
		ADDR_TAIL,
		ADDR_LIST_NEXT
	} addr_sel_t;

	typedef enum logic [1:0] {
		DSEL_ZERO,
		DSEL_RDATA,
		DSEL_HOLD
	} dsel_t;

	typedef enum logic [1:0] {
		PTR_KEEP,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef struct packed {
		logic      load_value;
		logic      rd_en;
		addr_sel_t rd_sel;
		logic      wr_en;
		addr_sel_t wr_sel;
		logic      wr_from_rdata;
		logic      hold_load;
		ptr_op_t   head_op;
		ptr_op_t   cnt_op;
		logic      list_clr;
		logic      list_inc;
		logic      emit;
		st_t       emit_status;
		dsel_t     emit_data;
		logic      emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
		logic full;
		logic out_free;
		logic list_last;
	} dp_stat_t;

endpackage

// ===== src/dque_in_if.sv =====
// Request channel: opcode and value with a valid/ready handshake.
interface dque_in_if;
	import dque_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ===== src/dque_out_if.sv =====
// Result channel: status, data, last mark and occupancy with a valid/ready handshake.
interface dque_out_if;
	import dque_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic signed [VALUE_W-1:0]  data;
	logic                       last;
	logic [OCC_W-1:0]           occupancy;

	modport source (output valid, output status, output data, output last, output occupancy,
		input ready);
	modport sink   (input valid, input status, input data, input last, input occupancy,
		output ready);
endinterface

// ===== src/dque_dp.sv =====
// Datapath: ring memory, head and count pointers, list index and result register.
module dque_dp #(
	parameter int unsigned DEPTH      = dque_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = dque_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [dque_pkg::VALUE_W-1:0]   value,
	input  dque_pkg::dp_cmd_t                     ctl,
	output dque_pkg::dp_stat_t                    stat,
	dque_out_if.source                            rsp
);
	import dque_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] TOP_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic [DATA_WIDTH-1:0] hold_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] wdata;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         cnt_m1;
	logic [CW-1:0]         cnt_nxt;
	logic [AW-1:0]         head_nxt;
	logic [AW:0]           head_x;
	logic [AW-1:0]         a_head_m1;
	logic [AW-1:0]         a_head_p1;
	logic [AW-1:0]         a_last;
	logic [AW-1:0]         a_tail;
	logic [AW-1:0]         a_list;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic                  out_valid_q;
	st_t                   out_status_q;
	logic [VALUE_W-1:0]    out_data_q;
	logic                  out_last_q;
	logic [OCC_W-1:0]      out_occ_q;
	logic [VALUE_W-1:0]    emit_data;

	// The sum is below twice the depth, so one conditional subtract folds it back.
	function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
		logic [AW:0] r;
		r = (s >= DEPTH_X) ? s - DEPTH_X : s;
		return r[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] pick(input addr_sel_t sel, input logic [AW-1:0] h,
		input logic [AW-1:0] hm1, input logic [AW-1:0] hp1, input logic [AW-1:0] lst,
		input logic [AW-1:0] tl, input logic [AW-1:0] ln);
		logic [AW-1:0] a;
		case (sel)
			ADDR_HEAD:      a = h;
			ADDR_HEAD_M1:   a = hm1;
			ADDR_HEAD_P1:   a = hp1;
			ADDR_LAST:      a = lst;
			ADDR_TAIL:      a = tl;
			ADDR_LIST_NEXT: a = ln;
			default:        a = h;
		endcase
		return a;
	endfunction

	assign cnt_m1    = cnt_q - CW'(1);
	assign head_x    = {1'b0, head_q};
	assign a_head_m1 = (head_q == '0) ? TOP_SLOT : head_q - AW'(1);
	assign a_head_p1 = (head_q == TOP_SLOT) ? '0 : head_q + AW'(1);
	assign a_last    = wrap(head_x + (AW + 1)'(cnt_m1));
	assign a_tail    = wrap(head_x + (AW + 1)'(cnt_q));
	assign a_list    = wrap(head_x + (AW + 1)'(idx_q + CW'(1)));
	assign raddr     = pick(ctl.rd_sel, head_q, a_head_m1, a_head_p1, a_last, a_tail, a_list);
	assign waddr     = pick(ctl.wr_sel, head_q, a_head_m1, a_head_p1, a_last, a_tail, a_list);
	assign wdata     = ctl.wr_from_rdata ? rdata_q : val_q;

	always_comb begin
		case (ctl.head_op)
			PTR_INC: head_nxt = a_head_p1;
			PTR_DEC: head_nxt = a_head_m1;
			default: head_nxt = head_q;
		endcase
		case (ctl.cnt_op)
			PTR_INC: cnt_nxt = cnt_q + CW'(1);
			PTR_DEC: cnt_nxt = cnt_m1;
			default: cnt_nxt = cnt_q;
		endcase
		case (ctl.emit_data)
			DSEL_RDATA: emit_data = VALUE_W'(rdata_q);
			DSEL_HOLD:  emit_data = VALUE_W'(hold_q);
			default:    emit_data = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_value) begin
			val_q <= DATA_WIDTH'(value);
		end
		if (ctl.hold_load) begin
			hold_q <= rdata_q;
		end
		if (ctl.emit) begin
			out_status_q <= ctl.emit_status;
			out_data_q   <= emit_data;
			out_last_q   <= ctl.emit_last;
			out_occ_q    <= OCC_W'(cnt_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			head_q <= head_nxt;
			cnt_q  <= cnt_nxt;
			if (ctl.list_clr) begin
				idx_q <= '0;
			end else if (ctl.list_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.cnt_one   = (cnt_q == CW'(1));
	assign stat.full      = (cnt_q == DEPTH_C);
	assign stat.out_free  = !out_valid_q || rsp.ready;
	assign stat.list_last = (idx_q == cnt_m1);

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.data      = out_data_q;
	assign rsp.last      = out_last_q;
	assign rsp.occupancy = out_occ_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= DEPTH_C)
		else $error("entry count exceeds the depth");
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n) head_q <= TOP_SLOT)
		else $error("head pointer outside the ring");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || rsp.ready))
		else $error("result overwritten before it was taken");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cnt_op == PTR_DEC) |-> (cnt_q != '0))
		else $error("pop on an empty list");
endmodule

// ===== src/dque_ctrl.sv =====
// Controller: decodes each request and steps the datapath through its memory accesses.
module dque_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  dque_pkg::op_t      cmd_opcode,
	input  dque_pkg::dp_stat_t stat,
	output dque_pkg::dp_cmd_t  ctl
);
	import dque_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD2,
		S_MV,
		S_FIN,
		S_LIST
	} state_t;

	typedef enum logic [2:0] {
		K_ERR,
		K_PFRONT,
		K_PBACK,
		K_INS2,
		K_INSNL,
		K_POP1,
		K_POP2,
		K_POPL
	} kind_t;

	state_t state_q;
	kind_t  kind_q;
	st_t    err_q;
	logic   accept;

	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.load_value = 1'b1;
					ctl.list_clr   = 1'b1;
					ctl.rd_en      = 1'b1;
					case (cmd_opcode)
						OP_INS_NLAST, OP_POP_LAST: ctl.rd_sel = ADDR_LAST;
						OP_POP_SECOND:             ctl.rd_sel = ADDR_HEAD_P1;
						default:                   ctl.rd_sel = ADDR_HEAD;
					endcase
				end
			end
			S_RD2: begin
				// Keep the second entry while the first one is fetched.
				ctl.hold_load = 1'b1;
				ctl.rd_en     = 1'b1;
				ctl.rd_sel    = ADDR_HEAD;
			end
			S_MV: begin
				ctl.wr_en         = 1'b1;
				ctl.wr_from_rdata = 1'b1;
				ctl.wr_sel        = (kind_q == K_INS2) ? ADDR_HEAD_M1 : ADDR_TAIL;
			end
			S_FIN: begin
				if (stat.out_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_last   = 1'b1;
					ctl.emit_status = ST_DONE;
					case (kind_q)
						K_PFRONT: begin
							ctl.wr_en   = 1'b1;
							ctl.wr_sel  = ADDR_HEAD_M1;
							ctl.head_op = PTR_DEC;
							ctl.cnt_op  = PTR_INC;
						end
						K_PBACK: begin
							ctl.wr_en  = 1'b1;
							ctl.wr_sel = ADDR_TAIL;
							ctl.cnt_op = PTR_INC;
						end
						K_INS2: begin
							// The old first entry already sits one slot before the head.
							ctl.wr_en   = 1'b1;
							ctl.wr_sel  = ADDR_HEAD;
							ctl.head_op = PTR_DEC;
							ctl.cnt_op  = PTR_INC;
						end
						K_INSNL: begin
							ctl.wr_en  = 1'b1;
							ctl.wr_sel = ADDR_LAST;
							ctl.cnt_op = PTR_INC;
						end
						K_POP1: begin
							ctl.emit_data = DSEL_RDATA;
							ctl.head_op   = PTR_INC;
							ctl.cnt_op    = PTR_DEC;
						end
						K_POP2: begin
							// Move the first entry into the second slot and advance the head.
							ctl.wr_en         = 1'b1;
							ctl.wr_sel        = ADDR_HEAD_P1;
							ctl.wr_from_rdata = 1'b1;
							ctl.emit_data     = DSEL_HOLD;
							ctl.head_op       = PTR_INC;
							ctl.cnt_op        = PTR_DEC;
						end
						K_POPL: begin
							ctl.emit_data = DSEL_RDATA;
							ctl.cnt_op    = PTR_DEC;
						end
						default: begin
							ctl.emit_status = err_q;
						end
					endcase
				end
			end
			S_LIST: begin
				if (stat.out_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = ST_DONE;
					ctl.emit_data   = DSEL_RDATA;
					ctl.emit_last   = stat.list_last;
					if (!stat.list_last) begin
						ctl.rd_en    = 1'b1;
						ctl.rd_sel   = ADDR_LIST_NEXT;
						ctl.list_inc = 1'b1;
					end
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_ERR;
			err_q   <= ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						kind_q  <= K_ERR;
						err_q   <= ST_EMPTY;
						case (cmd_opcode)
							OP_PUSH_FRONT: begin
								if (stat.full) err_q <= ST_FULL;
								else kind_q <= K_PFRONT;
							end
							OP_PUSH_BACK: begin
								if (stat.full) err_q <= ST_FULL;
								else kind_q <= K_PBACK;
							end
							OP_INS_SECOND: begin
								if (stat.cnt_zero) err_q <= ST_EMPTY;
								else if (stat.full) err_q <= ST_FULL;
								else if (stat.cnt_one) kind_q <= K_PBACK;
								else begin
									kind_q  <= K_INS2;
									state_q <= S_MV;
								end
							end
							OP_INS_NLAST: begin
								if (stat.cnt_zero) err_q <= ST_EMPTY;
								else if (stat.full) err_q <= ST_FULL;
								else if (stat.cnt_one) kind_q <= K_PFRONT;
								else begin
									kind_q  <= K_INSNL;
									state_q <= S_MV;
								end
							end
							OP_POP_FIRST: begin
								if (!stat.cnt_zero) kind_q <= K_POP1;
							end
							OP_POP_SECOND: begin
								if (stat.cnt_one) err_q <= ST_ONE;
								else if (!stat.cnt_zero) begin
									kind_q  <= K_POP2;
									state_q <= S_RD2;
								end
							end
							OP_POP_LAST: begin
								if (!stat.cnt_zero) kind_q <= K_POPL;
							end
							default: begin
								if (!stat.cnt_zero) state_q <= S_LIST;
							end
						endcase
					end
				end
				S_RD2:  state_q <= S_FIN;
				S_MV:   state_q <= S_FIN;
				S_FIN: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				S_LIST: begin
					if (stat.out_free && stat.list_last) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("request accepted without starting work");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && stat.out_free) |=> (state_q == S_IDLE))
		else $error("final step did not return to idle");
	a_list_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST && stat.out_free && stat.list_last) |=> (state_q == S_IDLE))
		else $error("listing continued past the last entry");
	a_single_mem_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.rd_en && ctl.wr_en))
		else $error("read and write issued in the same cycle");
endmodule

// ===== src/deque_with_near_end_insert_delete_top.sv =====
// Top level of the bounded deque with near-end insert and delete.
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    opcode[2:0], value[31:0] signed
//  rsp      out  valid/ready    status[1:0], data[31:0] signed, last, occupancy[4:0]
//
// Push front/back, pop first/last and refused operations go to the final step; insert
// second, insert next-to-last and pop second pass a move or second-read state, since the
// single-port ring memory needs a read and then two writes, or two reads and a write. A
// listing makes one memory read per entry. Reset clears head, count and control; the
// ring contents stay undefined until written. A stalled result holds the final step or
// the listing in place; no new request is taken until the last result is registered.
module deque_with_near_end_insert_delete_top #(
	parameter int unsigned DEPTH      = dque_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = dque_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dque_in_if.sink     cmd,
	dque_out_if.source  rsp
);
	import dque_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;
	logic     cmd_ready;

	assign cmd.ready = cmd_ready;

	dque_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_ready  (cmd_ready),
		.cmd_opcode (op_t'(cmd.opcode)),
		.stat       (stat),
		.ctl        (ctl)
	);

	dque_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (cmd.value),
		.ctl    (ctl),
		.stat   (stat),
		.rsp    (rsp)
	);
endmodule
